// ----- rtl/ole_pkg.sv -----
// shared types and codes for the ordered list engine
package ole_pkg;

    localparam int OpW   = 3;
    localparam int ValW  = 32;
    localparam int StW   = 2;

    typedef enum logic [OpW-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_INSERT     = 3'd2,
        OP_DELETE     = 3'd3,
        OP_FIND       = 3'd4,
        OP_SORT       = 3'd5
    } t_op;

    typedef enum logic [StW-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture transaction fields
        logic rd;       // issue read at read pointer
        logic wr;       // write value at write pointer
        logic wr_sel;   // 0: write read data, 1: write input value (current key in sort)
        logic ptr_dec;  // pointer minus one
        logic ptr_inc;  // pointer plus one
        logic ptr_pos;  // pointer to position
        logic ptr_cnt;  // pointer to count
        logic ptr_zero; // pointer to zero
        logic cnt_inc;
        logic cnt_dec;
        logic hold_cur; // latch read data as current key
        logic sk_init;  // sort outer index from one
        logic sk_inc;
        logic m_from_k;
        logic m_dec;
        logic hold_prev;
    } t_cmd;

endpackage

// ----- rtl/ole_ram.sv -----
// generic ram with one write port, one read port and registered read
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/ole_ctrl.sv -----
// controller state machine for the ordered list engine
module ole_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0]       i_operation,
    input  logic [$clog2(CAPACITY+1)-1:0] i_position,
    input  logic [$clog2(CAPACITY+1)-1:0] i_cnt,
    input  logic [$clog2(CAPACITY+1)-1:0] i_ptr,
    input  logic [$clog2(CAPACITY+1)-1:0] i_pos,
    input  logic [$clog2(CAPACITY+1)-1:0] i_sk,
    input  logic [$clog2(CAPACITY+1)-1:0] i_m,
    input  logic             i_match,
    input  logic             i_less,
    output ole_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done,
    output ole_pkg::t_status o_status,
    output logic             o_found
);
    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SRD   = 10'b0000000010,
        S_SWR   = 10'b0000000100,
        S_DRD   = 10'b0000001000,
        S_DWR   = 10'b0000010000,
        S_FRD   = 10'b0000100000,
        S_FCMP  = 10'b0001000000,
        S_KRD   = 10'b0010000000,
        S_KCUR  = 10'b0100000000,
        S_KCMP  = 10'b1000000000
    } t_state;

    t_state  r_state, n_state;
    logic    r_done, n_done;
    t_status r_status, n_status;
    logic    r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_status <= n_status;
        r_found  <= n_found;
    end

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_status = r_status;
        n_found  = r_found;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_found  = 1'b0;
                    o_cmd.load = 1'b1;
                    case (i_operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
                            if (i_cnt >= CAP) begin
                                n_status = ST_FULL; n_done = 1'b1;
                            end else if (i_operation == OP_INSERT && i_position > i_cnt) begin
                                n_status = ST_BADPOS; n_done = 1'b1;
                            end else begin
                                n_status = ST_OK;
                                o_cmd.ptr_cnt = 1'b1;
                                n_state = S_SRD;
                            end
                        end
                        OP_DELETE: begin
                            if (i_position >= i_cnt) begin
                                n_status = ST_BADPOS; n_done = 1'b1;
                            end else begin
                                n_status = ST_OK;
                                o_cmd.ptr_pos = 1'b1;
                                n_state = S_DRD;
                            end
                        end
                        OP_FIND: begin
                            n_status = ST_NOTFOUND;
                            o_cmd.ptr_zero = 1'b1;
                            n_state = S_FRD;
                        end
                        OP_SORT: begin
                            n_status = ST_OK;
                            o_cmd.sk_init = 1'b1;
                            n_state = S_KRD;
                        end
                        default: begin
                            n_status = ST_BADPOS; n_done = 1'b1;
                        end
                    endcase
                end
            end
            // shift up: entries[ptr] = entries[ptr-1] while ptr > pos
            S_SRD: begin
                if (i_ptr > i_pos) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_SWR;
                end else begin
                    o_cmd.wr = 1'b1; o_cmd.wr_sel = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SWR: begin
                o_cmd.wr = 1'b1;
                o_cmd.ptr_dec = 1'b1;
                n_state = S_SRD;
            end
            // shift down: entries[ptr] = entries[ptr+1]
            S_DRD: begin
                if (i_ptr + 1'b1 < i_cnt) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_DWR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DWR: begin
                o_cmd.wr = 1'b1;
                o_cmd.ptr_inc = 1'b1;
                n_state = S_DRD;
            end
            S_FRD: begin
                if (i_ptr < i_cnt) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_FCMP;
                end else begin
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FCMP: begin
                if (i_match) begin
                    n_status = ST_OK; n_found = 1'b1;
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state = S_FRD;
                end
            end
            // insertion sort: read entries[k] as key
            S_KRD: begin
                if (i_sk < i_cnt) begin
                    o_cmd.rd = 1'b1;
                    o_cmd.m_from_k = 1'b1;
                    n_state = S_KCUR;
                end else begin
                    n_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_KCUR: begin
                o_cmd.hold_cur = 1'b1;
                if (i_m != '0) begin
                    o_cmd.rd = 1'b1;
                    n_state = S_KCMP;
                end else begin
                    o_cmd.wr = 1'b1; o_cmd.wr_sel = 1'b1;
                    o_cmd.sk_inc = 1'b1;
                    n_state = S_KRD;
                end
            end
            S_KCMP: begin
                if (i_less) begin
                    o_cmd.wr = 1'b1;
                    o_cmd.m_dec = 1'b1;
                    n_state = S_KCUR;
                    o_cmd.hold_prev = 1'b1;
                end else begin
                    o_cmd.wr = 1'b1; o_cmd.wr_sel = 1'b1;
                    o_cmd.sk_inc = 1'b1;
                    n_state = S_KRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy   = (r_state != S_IDLE) || r_done;
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_found  = r_found;
endmodule

// ----- rtl/ole_dp.sv -----
// datapath of the ordered list engine: list memory, pointers and count
module ole_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ole_pkg::t_cmd                 i_cmd,
    input  logic [2:0]                    i_operation,
    input  logic [$clog2(CAPACITY+1)-1:0] i_position,
    input  logic [31:0]                   i_value,
    output logic [$clog2(CAPACITY+1)-1:0] o_cnt,
    output logic [$clog2(CAPACITY+1)-1:0] o_ptr,
    output logic [$clog2(CAPACITY+1)-1:0] o_pos,
    output logic [$clog2(CAPACITY+1)-1:0] o_sk,
    output logic [$clog2(CAPACITY+1)-1:0] o_m,
    output logic                          o_match,
    output logic                          o_less
);
    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);
    localparam int AW = $clog2(CAPACITY);

    logic [CW-1:0]   r_cnt, r_ptr, r_pos, r_sk, r_m;
    logic [ValW-1:0] r_val, r_cur;
    logic [ValW-1:0] rdata, wdata;
    logic [CW-1:0]   raddr, waddr;
    logic            r_keymode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.load) begin
            r_val <= i_value;
            case (i_operation)
                OP_PUSH_FRONT: r_pos <= '0;
                OP_PUSH_BACK:  r_pos <= r_cnt;
                default:       r_pos <= i_position;
            endcase
        end
        if (i_cmd.ptr_cnt) r_ptr <= r_cnt;
        else if (i_cmd.ptr_pos) r_ptr <= i_position;
        else if (i_cmd.ptr_zero) r_ptr <= '0;
        else if (i_cmd.ptr_dec) r_ptr <= r_ptr - 1'b1;
        else if (i_cmd.ptr_inc) r_ptr <= r_ptr + 1'b1;
        if (i_cmd.sk_init) r_sk <= CW'(1);
        else if (i_cmd.sk_inc) r_sk <= r_sk + 1'b1;
        if (i_cmd.m_from_k) r_m <= r_sk;
        else if (i_cmd.m_dec) r_m <= r_m - 1'b1;
        if (i_cmd.m_from_k) r_keymode <= 1'b1;
        else if (i_cmd.load) r_keymode <= 1'b0;
        if (i_cmd.hold_cur && !i_cmd.hold_prev && r_m == r_sk) r_cur <= rdata;
    end

    // address selection
    always_comb begin
        raddr = r_ptr;
        waddr = r_ptr;
        wdata = i_cmd.wr_sel ? (r_keymode ? r_cur : r_val) : rdata;
        if (r_keymode) begin
            raddr = i_cmd.m_from_k ? r_sk : r_m - 1'b1;
            waddr = r_m;
        end else if (i_cmd.wr_sel) begin
            waddr = r_pos;
        end else if (r_ptr > r_pos || !i_cmd.wr) begin
            raddr = (i_cmd.rd && r_ptr > r_pos && i_operation != OP_DELETE
                     && !i_cmd.ptr_inc) ? r_ptr - 1'b1 : r_ptr;
        end
    end

    logic [CW-1:0] rd_addr;
    always_comb begin
        rd_addr = raddr;
        if (!r_keymode && i_cmd.rd) begin
            case (i_operation)
                OP_DELETE: rd_addr = r_ptr + 1'b1;
                OP_FIND:   rd_addr = r_ptr;
                OP_SORT:   rd_addr = r_sk;
                default:   rd_addr = r_ptr - 1'b1;
            endcase
        end
    end

    ole_ram #(.WIDTH(ValW), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr),
        .i_waddr(waddr[AW-1:0]),
        .i_wdata(wdata),
        .i_raddr(rd_addr[AW-1:0]),
        .o_rdata(rdata)
    );

    assign o_cnt   = r_cnt;
    assign o_ptr   = r_ptr;
    assign o_pos   = r_pos;
    assign o_sk    = r_sk;
    assign o_m     = r_m;
    assign o_match = (rdata == r_val);
    assign o_less  = $signed(r_cur) < $signed(rdata);
endmodule

// ----- rtl/ordered_list_engine.sv -----
// top level of the ordered list engine
// one transaction at a time; busy stays high through the result strobe cycle
// the result strobe lasts one cycle and the receiver cannot stall it
// synchronous active-low reset empties the list; entries themselves are not cleared
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_found_index,
    output logic [6:0]  o_list_count
);
    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY+1);

    t_cmd          cmd;
    t_status       st;
    logic          found;
    logic [CW-1:0] cnt, ptr, pos, sk, m;
    logic          match, less;
    logic [2:0]    r_opq;
    logic [CW-1:0] pos_in;

    assign pos_in = (i_position > 7'(CAPACITY)) ? CW'(CAPACITY + 1 > (1 << CW) - 1
                    ? (1 << CW) - 1 : CAPACITY + 1) : CW'(i_position);

    always_ff @(posedge i_clk) begin
        if (cmd.load) r_opq <= i_operation;
    end

    ole_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(start && !busy), .i_operation(i_operation), .i_position(pos_in),
        .i_cnt(cnt), .i_ptr(ptr), .i_pos(pos), .i_sk(sk), .i_m(m),
        .i_match(match), .i_less(less),
        .o_cmd(cmd), .o_busy(busy), .o_done(o_valid), .o_status(st), .o_found(found)
    );

    ole_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_operation(cmd.load ? i_operation : r_opq), .i_position(pos_in),
        .i_value(i_value),
        .o_cnt(cnt), .o_ptr(ptr), .o_pos(pos), .o_sk(sk), .o_m(m),
        .o_match(match), .o_less(less)
    );

    assign o_status      = st;
    assign o_found_index = found ? 6'(ptr) : 6'd0;
    assign o_list_count  = 7'(cnt);
endmodule

// ----- rtl/ole_checker.sv -----
// port-level checks for the ordered list engine
module ole_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_status,
    input logic [5:0] o_found_index,
    input logic [6:0] o_list_count
);
    import ole_pkg::*;

    a_idle_no_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !o_valid) else $error("strobe while idle");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transaction not taken");
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_found_index == 6'd0)
        else $error("index on failed transaction");
endmodule

bind ordered_list_engine ole_checker u_chk (.*);

// ----- verif/ordered_list_checker.sv -----
// checker for the ordered list engine: list model, result prediction and comparison
`timescale 1ns / 1ps
module ordered_list_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [6:0]  i_position,
    input  logic [31:0] i_value,
    input  logic        o_valid,
    input  logic [1:0]  o_status,
    input  logic [5:0]  o_found_index,
    input  logic [6:0]  o_list_count,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import ole_pkg::*;

    localparam int Depth = 64;

    typedef struct packed {
        t_status    status;
        logic [5:0] index;
        logic [6:0] count;
    } t_outcome;

    logic signed [31:0] list_q [Depth];
    int                 list_len;
    t_outcome           outcome_q [$];

    function automatic t_status list_insert(int where, logic signed [31:0] v);
        if (list_len >= Depth) return ST_FULL;
        if (where > list_len) return ST_BADPOS;
        for (int k = list_len; k > where; k--) list_q[k] = list_q[k-1];
        list_q[where] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic t_outcome apply_request(logic [2:0] op, int where,
                                               logic signed [31:0] v);
        t_outcome o;
        logic signed [31:0] key;
        int m;
        o = '0;
        o.status = ST_OK;
        case (op)
            OP_PUSH_FRONT: o.status = list_insert(0, v);
            OP_PUSH_BACK:  o.status = list_insert(list_len, v);
            OP_INSERT:     o.status = list_insert(where, v);
            OP_DELETE: begin
                if (where >= list_len) o.status = ST_BADPOS;
                else begin
                    for (int k = where; k + 1 < list_len; k++) list_q[k] = list_q[k+1];
                    list_len--;
                end
            end
            OP_FIND: begin
                o.status = ST_NOTFOUND;
                for (int k = 0; k < list_len; k++) begin
                    if (list_q[k] == v) begin
                        o.status = ST_OK;
                        o.index = k[5:0];
                        break;
                    end
                end
            end
            OP_SORT: begin
                for (int k = 1; k < list_len; k++) begin
                    key = list_q[k];
                    m = k;
                    while (m > 0 && key < list_q[m-1]) begin
                        list_q[m] = list_q[m-1];
                        m--;
                    end
                    list_q[m] = key;
                end
            end
            default: o.status = ST_BADPOS;
        endcase
        o.count = list_len[6:0];
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            list_len = 0;
            outcome_q.delete();
            fail_count <= 0;
            result_count <= 0;
            pending_count <= 0;
        end else begin
            if (o_valid) begin
                result_count <= result_count + 1;
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d index=%0d count=%0d",
                             $time, o_status, o_found_index, o_list_count);
                    fail_count <= fail_count + 1;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_status !== want.status || o_found_index !== want.index ||
                        o_list_count !== want.count) begin
                        $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 $time, want.status, want.index, want.count,
                                 o_status, o_found_index, o_list_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_request(i_operation, int'(i_position),
                                                  $signed(i_value)));
            pending_count <= outcome_q.size();
        end
    end
endmodule

// ----- verif/tb_ordered_list_engine.sv -----
// testbench top for the ordered list engine: stimulus, timeout and verdict
`timescale 1ns / 1ps
module tb_ordered_list_engine;
    import ole_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_operation = '0;
    logic [6:0]  i_position = '0;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [5:0]  o_found_index;
    logic [6:0]  o_list_count;
    int          fail_count, pending_count, result_count;
    int          fill, sent;
    logic [31:0] recent [8];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    ordered_list_engine uut (.*);

    ordered_list_checker chk (.*);

    // one transaction, held until accepted; start stays high for the next one
    task automatic send_request(logic [2:0] op, logic [6:0] where, logic [31:0] v);
        i_operation <= op;
        i_position  <= where;
        i_value     <= v;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        recent[sent % 8] = v;
        sent++;
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_INSERT) &&
            fill < 64 && (op != OP_INSERT || where <= fill))
            fill++;
        else if (op == OP_DELETE && where < fill)
            fill--;
    endtask

    task automatic random_request();
        int r;
        logic [6:0] where;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        where = (fill > 0 && $urandom_range(0, 3) != 0) ?
                7'($urandom_range(0, fill)) : 7'($urandom);
        v = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) - 32'd4 : $urandom;
        if (sent > 0 && $urandom_range(0, 2) == 0) v = recent[$urandom_range(0, 7)];
        if (r < 20)      send_request(OP_PUSH_FRONT, where, v);
        else if (r < 40) send_request(OP_PUSH_BACK, where, v);
        else if (r < 58) send_request(OP_INSERT, where, v);
        else if (r < 76 - (fill > 40 ? 0 : 10)) send_request(OP_DELETE, where, v);
        else if (r < 90) send_request(OP_FIND, where, v);
        else if (r < 97) send_request(OP_SORT, where, v);
        else             send_request(3'($urandom_range(6, 7)), where, v);
    endtask

    initial begin
        fill = 0;
        sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty list cases, extremes, every operation
        send_request(OP_DELETE, 7'd0, 32'd0);
        send_request(OP_FIND, 7'd0, 32'd0);
        send_request(OP_SORT, 7'd0, 32'd0);
        send_request(OP_PUSH_BACK, 7'd127, 32'h7fffffff);
        send_request(OP_PUSH_FRONT, 7'd0, 32'h80000000);
        send_request(OP_INSERT, 7'd2, 32'hffffffff);
        send_request(OP_INSERT, 7'd4, 32'd5);
        send_request(OP_INSERT, 7'd1, 32'd0);
        send_request(OP_FIND, 7'd0, 32'hffffffff);
        send_request(OP_FIND, 7'd0, 32'd1234);
        send_request(OP_SORT, 7'd0, 32'd0);
        send_request(OP_FIND, 7'd0, 32'h7fffffff);
        send_request(3'd6, 7'd0, 32'd0);
        send_request(3'd7, 7'd0, 32'd0);
        send_request(OP_DELETE, 7'd4, 32'd0);
        send_request(OP_DELETE, 7'd3, 32'd0);
        send_request(OP_DELETE, 7'd0, 32'd0);
        // fill to capacity, then full cases
        while (fill < 64) send_request(OP_PUSH_BACK, 7'd0, $urandom);
        send_request(OP_PUSH_FRONT, 7'd0, 32'd1);
        send_request(OP_INSERT, 7'd64, 32'd1);
        send_request(OP_SORT, 7'd0, 32'd0);
        send_request(OP_DELETE, 7'd63, 32'd0);
        send_request(OP_INSERT, 7'd64, 32'd1);
        // let everything drain once
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        for (int n = 0; n < 320; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
            random_request();
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests, %0d results, list length %0d at end",
                 sent, result_count, fill);
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

    initial begin
        #200ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/ole_pkg.sv
rtl/ole_ram.sv
rtl/ole_ctrl.sv
rtl/ole_dp.sv
rtl/ordered_list_engine.sv
rtl/ole_checker.sv
verif/ordered_list_checker.sv
verif/tb_ordered_list_engine.sv
